/* hw/rtl/sfr_pkg.sv */
package sfr_pkg;

    // frame geometry
    localparam int FRAME_BYTES  = 25;
    localparam int CHANNELS_DEF = 16;
    localparam int STORE_DEPTH  = 2 * FRAME_BYTES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int CH_W         = 4;
    localparam int RAW_W        = 11;

    // byte positions of the status word
    localparam logic [POS_W-1:0] STAT_HI_POS = POS_W'(23);
    localparam logic [POS_W-1:0] STAT_LO_POS = POS_W'(24);
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);

    // configuration register resets
    localparam logic [7:0]  GAP_RESET   = 8'd2;
    localparam logic [10:0] FLOOR_RESET = 11'd350;
    localparam logic [19:0] SCALE_RESET = 20'd65536;
    localparam logic [15:0] BASE_RESET  = 16'd0;
    localparam logic [7:0]  IDLE_MAX    = 8'hFF;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_GAP   = 2'd0,
        REG_FLOOR = 2'd1,
        REG_SCALE = 2'd2,
        REG_BASE  = 2'd3
    } t_reg_idx;

    // store read address selection
    typedef enum logic [2:0] {
        RSEL_STAT_HI = 3'd0,
        RSEL_STAT_LO = 3'd1,
        RSEL_CH0     = 3'd2,
        RSEL_CH1     = 3'd3,
        RSEL_CH2     = 3'd4
    } t_rsel;

    // capture register selection
    typedef enum logic [2:0] {
        CAP_STAT_HI = 3'd0,
        CAP_STAT_LO = 3'd1,
        CAP_B0      = 3'd2,
        CAP_B1      = 3'd3,
        CAP_B2      = 3'd4
    } t_csel;

    // controller to datapath
    typedef struct packed {
        logic  in_ready;
        logic  rd_en;
        t_rsel rd_sel;
        logic  cap_en;
        t_csel cap_sel;
        logic  mul_en;
        logic  out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic decode_start;
        logic out_free;
        logic last_ch;
    } t_status;

endpackage

/* hw/rtl/sbus_frame_receiver.sv */
// ticks and ordinary bytes: one transaction per cycle while not stalled, no results
// frame start byte: input then stalls until every channel result is loaded,
// while the previous frame is read from the byte store (one write port, one read port)
// status bytes first, then per channel three byte reads, a multiply and an output load
// synchronous active-low reset clears control, config and store valid flags;
// unwritten store bytes read as zero, no clearing pass
module sbus_frame_receiver #(
    parameter int CHANNELS = sfr_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_channel_index,
    output logic [15:0] o_channel_value,
    output logic [15:0] o_status_word,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import sfr_pkg::*;

    t_cmd    ctl;
    t_status status;

    // frame decode sequencer
    sfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (ctl)
    );

    // byte store, decode datapath and registers
    sfr_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_status_word   (o_status_word),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .i_ctl           (ctl),
        .o_status        (status)
    );

    assign o_in_stall = ~ctl.in_ready;
    assign pready     = 1'b1;

endmodule

/* hw/rtl/sfr_ram.sv */
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sfr_ctrl.sv */
module sfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfr_pkg::t_status i_status,
    output sfr_pkg::t_cmd    o_cmd
);

    import sfr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_ST_HI   = 10'b00_0000_0010,
        S_ST_LO   = 10'b00_0000_0100,
        S_ST_CAP  = 10'b00_0000_1000,
        S_RD0     = 10'b00_0001_0000,
        S_RD1     = 10'b00_0010_0000,
        S_RD2     = 10'b00_0100_0000,
        S_RD3     = 10'b00_1000_0000,
        S_MUL     = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd.in_ready   = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = RSEL_STAT_HI;
        o_cmd.cap_en     = 1'b0;
        o_cmd.cap_sel    = CAP_STAT_HI;
        o_cmd.mul_en     = 1'b0;
        o_cmd.out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.decode_start) begin
                    n_state = S_ST_HI;
                end
            end
            S_ST_HI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RSEL_STAT_HI;
                n_state      = S_ST_LO;
            end
            S_ST_LO: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RSEL_STAT_LO;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_STAT_HI;
                n_state       = S_ST_CAP;
            end
            S_ST_CAP: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_STAT_LO;
                n_state       = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RSEL_CH0;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RSEL_CH1;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_B0;
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RSEL_CH2;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_B1;
                n_state       = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = CAP_B2;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_status.last_ch ? S_IDLE : S_RD0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/sfr_dp.sv */
module sfr_dp #(
    parameter int CHANNELS = sfr_pkg::CHANNELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     i_in_valid,
    input  logic                     i_cmd,
    input  logic [7:0]               i_rx_byte,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [3:0]               o_channel_index,
    output logic [15:0]              o_channel_value,
    output logic [15:0]              o_status_word,
    output logic                     o_last,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    // control
    input  sfr_pkg::t_cmd            i_ctl,
    output sfr_pkg::t_status         o_status
);

    import sfr_pkg::*;

    logic [7:0]         r_gap;
    logic [10:0]        r_floor;
    logic [19:0]        r_scale;
    logic [15:0]        r_base;

    logic               r_half;
    logic [POS_W-1:0]   r_pos;
    logic [7:0]         r_idle;
    logic [STORE_DEPTH-1:0] r_valid;

    logic [CH_W-1:0]    r_ch;
    logic [7:0]         r_st_hi;
    logic [7:0]         r_st_lo;
    logic [7:0]         r_b0;
    logic [7:0]         r_b1;
    logic [7:0]         r_b2;
    logic               r_rd_vld;
    logic [30:0]        r_prod;
    logic               r_above;

    logic               r_out_valid;
    logic [3:0]         r_out_idx;
    logic [15:0]        r_out_val;
    logic [15:0]        r_out_stat;
    logic               r_out_last;

    logic               accept;
    logic               is_byte;
    logic               start;
    logic               new_half;
    logic [POS_W-1:0]   wr_pos;
    logic [ADDR_W-1:0]  waddr;
    logic               we;

    logic [7:0]         bit_ofs;
    logic [POS_W-1:0]   ch_byte;
    logic [POS_W-1:0]   rd_pos;
    logic [ADDR_W-1:0]  raddr;
    logic [7:0]         rdata;
    logic [7:0]         mdata;

    logic [23:0]        word;
    logic [RAW_W-1:0]   raw;
    logic [RAW_W-1:0]   diff;
    logic [16:0]        sum;
    logic [15:0]        value;
    logic               apb_wr;

    // input transaction and frame boundary detection
    assign accept   = i_in_valid & i_ctl.in_ready;
    assign is_byte  = (i_cmd == CMD_BYTE);
    assign start    = r_idle > r_gap;
    assign new_half = start ? ~r_half : r_half;
    assign wr_pos   = start ? '0 : r_pos;
    assign waddr    = (new_half ? ADDR_W'(FRAME_BYTES) : ADDR_W'(0)) + ADDR_W'(wr_pos);
    assign we       = accept & is_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 1'b0;
            r_pos   <= '0;
            r_idle  <= IDLE_MAX;
            r_valid <= '0;
        end else if (accept) begin
            if (!is_byte) begin
                if (r_idle != IDLE_MAX) begin
                    r_idle <= r_idle + 8'd1;
                end
            end else begin
                r_half         <= new_half;
                r_pos          <= (wr_pos == LAST_POS) ? LAST_POS : wr_pos + POS_W'(1);
                r_idle         <= '0;
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    // read address into the finished half
    assign bit_ofs = 8'(r_ch) * 8'd11;
    assign ch_byte = POS_W'(1) + POS_W'(bit_ofs[7:3]);

    always_comb begin
        case (i_ctl.rd_sel)
            RSEL_STAT_HI: rd_pos = STAT_HI_POS;
            RSEL_STAT_LO: rd_pos = STAT_LO_POS;
            RSEL_CH0:     rd_pos = ch_byte;
            RSEL_CH1:     rd_pos = ch_byte + POS_W'(1);
            RSEL_CH2:     rd_pos = ch_byte + POS_W'(2);
            default:      rd_pos = ch_byte;
        endcase
    end

    assign raddr = (r_half ? ADDR_W'(0) : ADDR_W'(FRAME_BYTES)) + ADDR_W'(rd_pos);

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_re    (i_ctl.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_vld <= r_valid[raddr];
        end
    end

    assign mdata = r_rd_vld ? rdata : 8'd0;

    // byte capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_en) begin
            case (i_ctl.cap_sel)
                CAP_STAT_HI: r_st_hi <= mdata;
                CAP_STAT_LO: r_st_lo <= mdata;
                CAP_B0:      r_b0    <= mdata;
                CAP_B1:      r_b1    <= mdata;
                CAP_B2:      r_b2    <= mdata;
                default:     r_b0    <= mdata;
            endcase
        end
    end

    // channel extraction and gain multiply
    assign word = {r_b2, r_b1, r_b0} >> bit_ofs[2:0];
    assign raw  = word[RAW_W-1:0];
    assign diff = raw - r_floor;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_above <= raw > r_floor;
            r_prod  <= 31'(diff) * 31'(r_scale);
        end
    end

    // offset and saturation
    assign sum   = 17'(r_prod[30:16]) + 17'(r_base);
    assign value = !r_above ? 16'd0 : (sum[16] ? 16'hFFFF : sum[15:0]);

    // channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (accept & is_byte & start) begin
            r_ch <= '0;
        end else if (i_ctl.out_load) begin
            r_ch <= r_ch + CH_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_idx  <= r_ch;
            r_out_val  <= value;
            r_out_stat <= {r_st_hi, r_st_lo};
            r_out_last <= o_status.last_ch;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_status_word   = r_out_stat;
    assign o_last          = r_out_last;

    // status back to the controller
    assign o_status.decode_start = accept & is_byte & start;
    assign o_status.out_free     = !r_out_valid || !i_out_stall;
    assign o_status.last_ch      = (r_ch == CH_W'(CHANNELS - 1));

    // configuration registers
    assign apb_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_floor <= FLOOR_RESET;
            r_scale <= SCALE_RESET;
            r_base  <= BASE_RESET;
        end else if (apb_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_GAP:   r_gap   <= pwdata[7:0];
                REG_FLOOR: r_floor <= pwdata[10:0];
                REG_SCALE: r_scale <= pwdata[19:0];
                REG_BASE:  r_base  <= pwdata[15:0];
                default:   r_gap   <= r_gap;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_GAP:   prdata = 32'(r_gap);
            REG_FLOOR: prdata = 32'(r_floor);
            REG_SCALE: prdata = 32'(r_scale);
            REG_BASE:  prdata = 32'(r_base);
            default:   prdata = '0;
        endcase
    end

endmodule
